>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the window autoscaler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i, off while in reset
`define SWA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen out of reset
`define SWA_ASSERT_NEVER(name, cond, msg) \
  `SWA_ASSERT(name, !(cond), msg)

`endif

>>> hw/rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Types and constants shared by the sliding window autoscaler modules.
// ----------------------------------------------------------------------------
package swa_pkg;

  // Window size default and field widths
  localparam int unsigned WINDOW_DEPTH_DEF = 100;
  localparam int unsigned SAMPLE_W         = 32;
  localparam int unsigned MIN_SPAN_W       = 31;
  localparam int unsigned MARGIN_W         = 16;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // Register reset values
  localparam logic [MIN_SPAN_W-1:0] MIN_SPAN_RST    = 31'd65536;
  localparam logic [MARGIN_W-1:0]   MARGIN_FRAC_RST = 16'd6554;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SPAN    = 2'd0,
    REG_MARGIN_FRAC = 2'd1
  } cfg_reg_e;

  // Live configuration handed to the back end
  typedef struct packed {
    logic [MIN_SPAN_W-1:0] min_span;
    logic [MARGIN_W-1:0]   margin_frac;
  } cfg_t;

  // One finished result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] scale_low;
    logic signed [SAMPLE_W-1:0] scale_high;
    logic signed [SAMPLE_W-1:0] show_low;
    logic signed [SAMPLE_W-1:0] show_high;
  } result_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SHOW,
    ST_DONE
  } back_state_e;

endpackage

>>> hw/rtl/swa_ram.sv
// ----------------------------------------------------------------------------
// swa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
  parameter int unsigned WIDTH = swa_pkg::SAMPLE_W,
  parameter int unsigned DEPTH = swa_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/swa_queue.sv
// ----------------------------------------------------------------------------
// swa_queue
// Front end: accepts sample items and buffers them for the back end.
// ----------------------------------------------------------------------------
module swa_queue #(
  parameter int unsigned WIDTH = swa_pkg::SAMPLE_W,
  parameter int unsigned DEPTH = swa_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_stall_o = (count_q == CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Item storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/swa_back.sv
// ----------------------------------------------------------------------------
// swa_back
// Back end: writes each sample into the window ring, scans the window for
// its extremes and band counts, updates the scale and forms the display range.
// ----------------------------------------------------------------------------
module swa_back #(
  parameter int unsigned WINDOW_DEPTH = swa_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  swa_pkg::cfg_t                        cfg_i,
  input  logic                                 item_valid_i,
  output logic                                 item_ready_o,
  input  logic signed [swa_pkg::SAMPLE_W-1:0]  item_sample_i,
  output logic                                 res_valid_o,
  input  logic                                 res_stall_i,
  output swa_pkg::result_t                     res_o
);

  localparam int unsigned SW = swa_pkg::SAMPLE_W;

  swa_pkg::back_state_e state_q, state_d;

  // Control state
  logic [IDX_W-1:0]     slot_q;
  logic [CNT_W-1:0]     fill_q;
  logic signed [SW-1:0] held_low_q, held_high_q;
  logic                 have_scale_q;
  logic [CNT_W-1:0]     rd_idx_q;
  logic                 rd_vld_q, d_vld_q;
  logic                 res_valid_q;

  // Datapath registers
  logic signed [SW-1:0] sample_q;
  logic signed [SW:0]   d_q;
  logic signed [SW-1:0] v_q;
  logic signed [SW-1:0] wmin_q, wmax_q;
  logic [CNT_W-1:0]     below_q, above_q;
  logic signed [SW+3:0] span_q, span4_q;
  logic [SW+15:0]       prod_q;
  logic signed [SW+1:0] show_lo_q, show_hi_q, alt_q;
  swa_pkg::result_t     res_q;

  // Sequencer outputs
  logic ram_we, ram_re, res_load;
  logic [SW-1:0] ram_rdata;

  // Combinational helpers
  logic signed [SW:0]   span33;
  logic signed [SW+3:0] d36, five_d;
  logic [CNT_W+2:0]     below5, above5, fill_ext;
  logic signed [SW-1:0] new_low, new_high;
  logic [SW-1:0]        mag_sel;
  logic [SW-1:0]        margin_mag;
  logic signed [SW+1:0] show_hi_pick;
  logic                 res_free;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [SW-1:0] sat34(input logic signed [SW+1:0] x);
    logic signed [SW-1:0] r;
    if ((x[SW+1:SW-1] == 3'b000) || (x[SW+1:SW-1] == 3'b111)) begin
      r = x[SW-1:0];
    end else if (x[SW+1]) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SW-1){1'b1}}};
    end
    return r;
  endfunction

  // Magnitude of a signed value, exact for the most negative code
  function automatic logic [SW-1:0] mag32(input logic signed [SW-1:0] x);
    logic [SW-1:0] r;
    r = x[SW-1] ? (~x + 1'b1) : x;
    return r;
  endfunction

  // Window memory
  swa_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer outputs
  always_comb begin
    item_ready_o = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    res_load     = 1'b0;
    case (state_q)
      swa_pkg::ST_IDLE: item_ready_o = 1'b1;
      swa_pkg::ST_LOAD: ram_we = 1'b1;
      swa_pkg::ST_SCAN: ram_re = (rd_idx_q < fill_q);
      swa_pkg::ST_DONE: res_load = res_free;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swa_pkg::ST_IDLE:   if (item_valid_i) state_d = swa_pkg::ST_LOAD;
      swa_pkg::ST_LOAD:   state_d = swa_pkg::ST_SCAN;
      swa_pkg::ST_SCAN: begin
        if (!ram_re && !rd_vld_q && !d_vld_q) state_d = swa_pkg::ST_DECIDE;
      end
      swa_pkg::ST_DECIDE: state_d = swa_pkg::ST_MUL_LO;
      swa_pkg::ST_MUL_LO: state_d = swa_pkg::ST_MUL_HI;
      swa_pkg::ST_MUL_HI: state_d = swa_pkg::ST_SHOW;
      swa_pkg::ST_SHOW:   state_d = swa_pkg::ST_DONE;
      swa_pkg::ST_DONE:   if (res_free) state_d = swa_pkg::ST_IDLE;
      default:            state_d = swa_pkg::ST_IDLE;
    endcase
  end

  // Scan arithmetic: 5*(v-low) against span and 4*span
  assign span33   = $signed({held_high_q[SW-1], held_high_q})
                  - $signed({held_low_q[SW-1], held_low_q});
  assign d36      = {{3{d_q[SW]}}, d_q};
  assign five_d   = (d36 <<< 2) + d36;
  assign below5   = ({3'b000, below_q} << 2) + {3'b000, below_q};
  assign above5   = ({3'b000, above_q} << 2) + {3'b000, above_q};
  assign fill_ext = {3'b000, fill_q};

  // Scale decision
  always_comb begin
    new_low  = held_low_q;
    new_high = held_high_q;
    if (!have_scale_q) begin
      new_low  = wmin_q;
      new_high = wmax_q;
    end else begin
      if ((wmin_q < held_low_q) || (below5 < fill_ext)) new_low = wmin_q;
      if ((wmax_q > held_high_q) || (above5 < fill_ext)) new_high = wmax_q;
    end
  end

  // Shared margin multiplier input
  assign mag_sel    = (state_q == swa_pkg::ST_MUL_LO) ? mag32(held_low_q)
                                                      : mag32(held_high_q);
  assign margin_mag = prod_q[SW+15:16];

  assign show_hi_pick = (alt_q > show_hi_q) ? alt_q : show_hi_q;
  assign res_free     = !res_valid_q || !res_stall_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swa_pkg::ST_IDLE;
      slot_q       <= '0;
      fill_q       <= '0;
      held_low_q   <= '0;
      held_high_q  <= '0;
      have_scale_q <= 1'b0;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      d_vld_q      <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re;
      d_vld_q  <= rd_vld_q;
      if (ram_we) begin
        slot_q   <= (slot_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        if (fill_q < CNT_W'(WINDOW_DEPTH)) fill_q <= fill_q + 1'b1;
        rd_idx_q <= '0;
      end else if (ram_re) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (state_q == swa_pkg::ST_DECIDE) begin
        held_low_q   <= new_low;
        held_high_q  <= new_high;
        have_scale_q <= 1'b1;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      sample_q <= item_sample_i;
    end
    // scan stage one: difference to the held low
    if (rd_vld_q) begin
      v_q <= ram_rdata;
      d_q <= $signed({ram_rdata[SW-1], ram_rdata})
           - $signed({held_low_q[SW-1], held_low_q});
    end
    // scan set-up and stage two: extremes and band counts
    if (ram_we) begin
      wmin_q  <= {1'b0, {(SW-1){1'b1}}};
      wmax_q  <= {1'b1, {(SW-1){1'b0}}};
      below_q <= '0;
      above_q <= '0;
      span_q  <= {{3{span33[SW]}}, span33};
      span4_q <= {{3{span33[SW]}}, span33} <<< 2;
    end else if (d_vld_q) begin
      if (v_q < wmin_q) wmin_q <= v_q;
      if (v_q > wmax_q) wmax_q <= v_q;
      if (five_d < span_q)  below_q <= below_q + 1'b1;
      if (five_d > span4_q) above_q <= above_q + 1'b1;
    end
    // margin products, one per cycle
    if ((state_q == swa_pkg::ST_MUL_LO) || (state_q == swa_pkg::ST_MUL_HI)) begin
      prod_q <= mag_sel * cfg_i.margin_frac;
    end
    if (state_q == swa_pkg::ST_MUL_HI) begin
      show_lo_q <= {{2{held_low_q[SW-1]}}, held_low_q} - {2'b00, margin_mag};
    end
    if (state_q == swa_pkg::ST_SHOW) begin
      show_hi_q <= held_high_q[SW-1]
                 ? {{2{held_high_q[SW-1]}}, held_high_q} - {2'b00, margin_mag}
                 : {{2{held_high_q[SW-1]}}, held_high_q} + {2'b00, margin_mag};
      alt_q     <= {{2{held_low_q[SW-1]}}, held_low_q} + {3'b000, cfg_i.min_span};
    end
    // result register
    if (res_load) begin
      res_q.scale_low  <= held_low_q;
      res_q.scale_high <= held_high_q;
      res_q.show_low   <= sat34(show_lo_q);
      res_q.show_high  <= sat34(show_hi_pick);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/sliding_window_autoscale.sv
// ----------------------------------------------------------------------------
// sliding_window_autoscale
// Autoscaler over the last WINDOW_DEPTH Q16.16 samples with display margin.
// ----------------------------------------------------------------------------
// Each sample item gives one result item. The back end reads the n samples
// held in the window (up to WINDOW_DEPTH) one entry per cycle through the
// single read port of the window memory, then updates the scale and forms
// the two margin products of its shared multiplier. A two-entry queue in
// front takes new samples while the back end is busy, and a finished result
// waits in an output register while the next sample is worked on; that
// sample's result waits in turn until the register is free. Configuration
// writes are always taken (cfg_ready_o stays high) and take effect at once,
// also on a sample already being worked on, so write them only while no
// sample is in flight.
`include "assert_macros.svh"

module sliding_window_autoscale #(
  parameter int unsigned WINDOW_DEPTH = swa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [swa_pkg::SAMPLE_W-1:0]   sample_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [swa_pkg::SAMPLE_W-1:0]   scale_low_o,
  output logic signed [swa_pkg::SAMPLE_W-1:0]   scale_high_o,
  output logic signed [swa_pkg::SAMPLE_W-1:0]   show_low_o,
  output logic signed [swa_pkg::SAMPLE_W-1:0]   show_high_o,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [swa_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [swa_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  swa_pkg::cfg_t    cfg_q;
  swa_pkg::result_t res;

  logic                                q_valid;
  logic                                back_ready;
  logic signed [swa_pkg::SAMPLE_W-1:0] q_sample;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_span    <= swa_pkg::MIN_SPAN_RST;
      cfg_q.margin_frac <= swa_pkg::MARGIN_FRAC_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        swa_pkg::REG_MIN_SPAN:    cfg_q.min_span    <= cfg_data_i[swa_pkg::MIN_SPAN_W-1:0];
        swa_pkg::REG_MARGIN_FRAC: cfg_q.margin_frac <= cfg_data_i[swa_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end queue
  swa_queue #(
    .WIDTH (swa_pkg::SAMPLE_W),
    .DEPTH (swa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (sample_i),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (q_sample)
  );

  // Back end engine
  swa_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (q_valid),
    .item_ready_o  (back_ready),
    .item_sample_i (q_sample),
    .res_valid_o   (out_valid_o),
    .res_stall_i   (out_stall_i),
    .res_o         (res)
  );

  assign scale_low_o  = res.scale_low;
  assign scale_high_o = res.scale_high;
  assign show_low_o   = res.show_low;
  assign show_high_o  = res.show_high;

  // Checks
  `SWA_ASSERT_NEVER(a_full_queue_empty, in_stall_o && !q_valid, "queue stalls while empty")
  `SWA_ASSERT(a_result_from_busy, $rose(out_valid_o) |-> $past(!back_ready), "result from idle back end")
  `SWA_ASSERT(a_result_order, out_valid_o |-> (scale_low_o <= scale_high_o) && (show_low_o <= scale_low_o) && (show_high_o >= scale_low_o), "result bounds out of order")

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the sliding window autoscaler against a cycle-free model of its
// scale tracking. Samples go in through the valid/stall channel with random
// gaps, results come back under random stalls, and every result item is
// compared field by field with the predicted scale and display range.
// ----------------------------------------------------------------------------
module testbench;

  import swa_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int WIN_DEPTH      = WINDOW_DEPTH_DEF;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  localparam logic signed [SAMPLE_W-1:0] MAX_S32 = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_W-1:0] MIN_S32 = 32'sh8000_0000;

  // Indexes past the register file, writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Shapes of random sample runs
  typedef enum int {
    SEG_FULL,
    SEG_TIES,
    SEG_POS,
    SEG_NEG,
    SEG_WALK
  } seg_kind_e;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] scale_low_o;
  logic signed [SAMPLE_W-1:0] scale_high_o;
  logic signed [SAMPLE_W-1:0] show_low_o;
  logic signed [SAMPLE_W-1:0] show_high_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i  = '0;

  // Mirror of the block state
  logic signed [SAMPLE_W-1:0] window_copy [WIN_DEPTH];
  int unsigned                next_slot  = 0;
  int unsigned                held_count = 0;
  logic signed [SAMPLE_W-1:0] scale_lo   = '0;
  logic signed [SAMPLE_W-1:0] scale_hi   = '0;
  bit                         scale_seen = 1'b0;
  logic [MIN_SPAN_W-1:0]      span_reg   = MIN_SPAN_RST;
  logic [MARGIN_W-1:0]        margin_reg = MARGIN_FRAC_RST;

  result_t pending_scales[$];
  int      mismatches = 0;

  // Idle control shared by sender and receiver
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;
  bit hold_request = 1'b0;
  int stall_left   = 0;
  bit tx_offering  = 1'b0;

  sliding_window_autoscale #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scale_low_o (scale_low_o),
    .scale_high_o(scale_high_o),
    .show_low_o  (show_low_o),
    .show_high_o (show_high_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scale prediction
  // ---------------------------------------------------------------------------

  // Margin magnitude, truncated towards zero
  function automatic longint margin_of(input logic signed [SAMPLE_W-1:0] v);
    longint mag;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    return (mag * longint'(margin_reg)) >>> 16;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp32(input longint v);
    if (v > longint'(MAX_S32)) return MAX_S32;
    if (v < longint'(MIN_S32)) return MIN_S32;
    return v[SAMPLE_W-1:0];
  endfunction

  // Store one sample and work out the scale and display range it gives
  function automatic result_t predict_scale(input logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W-1:0] wlo, whi, lo, hi;
    longint                     span, d, shw_lo, shw_hi, alt;
    int unsigned                below, above;
    result_t                    r;
    wlo   = MAX_S32;
    whi   = MIN_S32;
    below = 0;
    above = 0;
    window_copy[next_slot] = s;
    next_slot = (next_slot + 1) % WIN_DEPTH;
    if (held_count < WIN_DEPTH) held_count++;
    for (int i = 0; i < held_count; i++) begin
      if (window_copy[i] < wlo) wlo = window_copy[i];
      if (window_copy[i] > whi) whi = window_copy[i];
    end
    lo = scale_lo;
    hi = scale_hi;
    if (scale_seen) begin
      // band counts against the scale held before this sample
      span = longint'(hi) - longint'(lo);
      for (int i = 0; i < held_count; i++) begin
        d = longint'(window_copy[i]) - longint'(lo);
        if (5 * d < span) below++;
        if (5 * d > 4 * span) above++;
      end
      if (wlo < lo || below * 5 < held_count) lo = wlo;
      if (whi > hi || above * 5 < held_count) hi = whi;
    end else begin
      lo = wlo;
      hi = whi;
      scale_seen = 1'b1;
    end
    scale_lo = lo;
    scale_hi = hi;
    shw_lo = longint'(lo) - margin_of(lo);
    shw_hi = (hi < 0) ? longint'(hi) - margin_of(hi) : longint'(hi) + margin_of(hi);
    alt    = longint'(lo) + longint'(span_reg);
    if (alt > shw_hi) shw_hi = alt;
    r.scale_low  = lo;
    r.scale_high = hi;
    r.show_low   = clamp32(shw_lo);
    r.show_high  = clamp32(shw_hi);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input logic signed [SAMPLE_W-1:0] want,
                             input logic signed [SAMPLE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, what, want, want,
               got, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_scales.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, expected none, got %0d %0d %0d %0d",
                 $time, scale_low_o, scale_high_o, show_low_o, show_high_o);
      end else begin
        want = pending_scales.pop_front();
        check_field("scale_low", want.scale_low, scale_low_o);
        check_field("scale_high", want.scale_high, scale_high_o);
        check_field("show_low", want.show_low, show_low_o);
        check_field("show_high", want.show_high, show_high_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling on both sides
  // ---------------------------------------------------------------------------

  // Mostly no gap, sometimes short, rarely long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(60, 200);
  endfunction

  // Receiver stalls, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left   = HOLD_CYCLES;
    end else if (stall_left == 0 && !rx_quiet) begin
      stall_left = pick_idle();
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------

  // Take valid down once, only if an item is still being offered
  task automatic drop_valid();
    if (tx_offering) begin
      in_valid_i  <= 1'b0;
      tx_offering = 1'b0;
    end
  endtask

  // Offer one sample and hold it until taken; valid stays up for the caller
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    sample_i    <= s;
    in_valid_i  <= 1'b1;
    tx_offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_scales.insert(pending_scales.size(), predict_scale(s));
  endtask

  task automatic idle_sender();
    int gap;
    gap = tx_quiet ? 0 : pick_idle();
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding result item
  task automatic drain_results();
    drop_valid();
    @(posedge clk_i);
    while (pending_scales.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write; valid stays up for the caller
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MIN_SPAN) span_reg = data[MIN_SPAN_W-1:0];
    else if (idx == REG_MARGIN_FRAC) margin_reg = data[MARGIN_W-1:0];
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] span_data,
                               input logic [CFG_DATA_W-1:0] margin_data);
    write_register(REG_MIN_SPAN, span_data);
    write_register(REG_MARGIN_FRAC, margin_data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random sample runs of varied shape until count items have gone in
  task automatic run_segments(input int count);
    int                         done, len, step;
    seg_kind_e                  kind;
    logic signed [SAMPLE_W-1:0] s, pos, base;
    done = 0;
    pos  = '0;
    while (done < count) begin
      kind     = seg_kind_e'($urandom_range(0, 4));
      len      = $urandom_range(20, 160);
      if (len > count - done) len = count - done;
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      base     = $urandom_range(0, 40) - 20;
      step     = $urandom_range(1, 32'h0004_0000);
      for (int k = 0; k < len; k++) begin
        case (kind)
          SEG_FULL: s = $urandom;
          SEG_TIES: s = base + $urandom_range(0, 10);
          SEG_POS:  s = $urandom_range(0, 32'h0100_0000);
          SEG_NEG:  s = 0 - $urandom_range(1, 32'h0100_0000);
          default: begin
            // slow drift with the odd spike
            pos = pos + ($urandom_range(0, 2 * step) - step);
            s   = ($urandom_range(0, 99) < 3) ? $urandom : pos;
          end
        endcase
        push_sample(s);
        idle_sender();
      end
      done += len;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Scale taken straight from the window on the very first item
  task automatic test_first_sample();
    push_sample(32'sh0003_8000);
    idle_sender();
    push_sample(-32'sh0001_4000);
    idle_sender();
  endtask

  // Extremes of the sample field, including saturating display bounds
  task automatic test_field_extremes();
    push_sample(MAX_S32);
    push_sample(MIN_S32);
    push_sample(32'sh0000_0000);
    idle_sender();
    push_sample(-32'sh0000_0001);
    push_sample(32'sh0000_0001);
    push_sample(32'sh0001_0000);
    idle_sender();
    push_sample(-32'sh0001_0000);
    push_sample(32'sh5555_5555);
    push_sample(32'shaaaa_aaaa);
    idle_sender();
  endtask

  // Register masking, ignored indexes, both extremes of each register
  task automatic test_register_extremes();
    drain_results();
    write_register(REG_MIN_SPAN, 32'hffff_ffff);
    write_register(REG_MARGIN_FRAC, 32'hffff_ffff);
    write_register(REG_SPARE_A, 32'h0000_0000);
    write_register(REG_SPARE_B, 32'h0000_0000);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    push_sample(32'sh4000_0000);
    push_sample(-32'sh0002_0000);
    push_sample(32'sh0000_1234);
    drain_results();
    set_registers(32'h8000_0000, 32'habcd_0000);
    push_sample(32'sh0000_0000);
    push_sample(32'sh7000_0000);
    push_sample(-32'sh7000_0000);
    idle_sender();
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls
  task automatic test_backpressure();
    drain_results();
    hold_request = 1'b1;
    for (int k = 0; k < 16; k++) push_sample($urandom);
    idle_sender();
  endtask

  // Sender pauses mid-stream until every result item has come back
  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) begin
      push_sample($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
      idle_sender();
    end
    drain_results();
    for (int k = 0; k < 10; k++) begin
      push_sample($urandom);
      idle_sender();
    end
  endtask

  // Random runs under several register settings
  task automatic test_random_windows();
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: set_registers(CFG_DATA_W'(MIN_SPAN_RST), CFG_DATA_W'(MARGIN_FRAC_RST));
        1: set_registers($urandom_range(0, 32'h0010_0000), $urandom);
        2: set_registers(32'h7fff_ffff, 32'h0000_0000);
        default: set_registers(32'h0000_0000, 32'h0000_ffff);
      endcase
      run_segments(150);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_sample();
    test_field_extremes();
    test_register_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_windows();
    drop_valid();
    while (pending_scales.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sliding_window_autoscale: match");
    end else begin
      $display("sliding_window_autoscale: mismatch");
    end
    $finish;
  end

  // Hard limit on run length
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("sliding_window_autoscale: mismatch");
    $finish;
  end

endmodule
